[sv/cfm_pkg.sv]
package cfm_pkg;

    // Field widths of the stream payloads
    localparam int CAPTURE_W = 16;
    localparam int PERIOD_W  = 16;
    localparam int FREQ_W    = 32;
    localparam int S_DATA_W  = CAPTURE_W;
    localparam int M_DATA_W  = PERIOD_W + FREQ_W;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_CLOCK_HZ = CFG_IDX_W'(0);
    localparam logic [CFG_DATA_W-1:0] CLOCK_HZ_RESET  = 32'd168000000;

    // Counter width default and divider length
    localparam int COUNTER_BITS_DEFAULT = 16;
    localparam int DIV_STEPS  = FREQ_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } cfm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_first;
        logic start;
        logic step;
        logic load_out;
    } cfm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic zero_period;
        logic out_free;
    } cfm_status_t;

endpackage

[sv/cfm_ctrl.sv]
module cfm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  cfm_pkg::cfm_status_t status,
    output cfm_pkg::cfm_cmd_t    cmd
);
    import cfm_pkg::*;

    cfm_state_t            state_reg, state_next;
    logic                  pending_reg, pending_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        pending_next  = pending_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (!pending_reg) begin
                        cmd.load_first = 1'b1;
                        pending_next   = 1'b1;
                    end else begin
                        cmd.start    = 1'b1;
                        pending_next = 1'b0;
                        cnt_next     = '0;
                        // skip the divider when the captures match
                        state_next   = status.zero_period ? ST_HOLD : ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + STEP_CNT_W'(1);
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/cfm_datapath.sv]
module cfm_datapath #(
    parameter int COUNTER_BITS = cfm_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [cfm_pkg::S_DATA_W-1:0]    s_axis_tdata,
    input  logic [cfm_pkg::CFG_DATA_W-1:0]  clock_hz,
    input  cfm_pkg::cfm_cmd_t               cmd,
    output cfm_pkg::cfm_status_t            status,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cfm_pkg::M_DATA_W-1:0]    m_axis_tdata,
    output logic                            m_axis_tuser
);
    import cfm_pkg::*;

    localparam int SMP_W = (COUNTER_BITS < CAPTURE_W) ? COUNTER_BITS : CAPTURE_W;
    localparam int EXT_W = (COUNTER_BITS > PERIOD_W) ? COUNTER_BITS : PERIOD_W;

    logic [SMP_W-1:0]        first_reg;
    logic [COUNTER_BITS-1:0] divisor_reg;
    logic [COUNTER_BITS-1:0] rem_reg;
    logic [FREQ_W-1:0]       quo_reg;
    logic                    zero_reg;
    logic [PERIOD_W-1:0]     period_reg;
    logic                    out_valid_reg;
    logic [M_DATA_W-1:0]     out_data_reg;
    logic                    out_zero_reg;

    logic [SMP_W-1:0]        sample;
    logic [COUNTER_BITS-1:0] period_full;
    logic [EXT_W-1:0]        period_ext;
    logic [COUNTER_BITS:0]   shifted;
    logic [COUNTER_BITS:0]   diff;
    logic                    fits;

    assign sample      = s_axis_tdata[SMP_W-1:0];
    assign period_full = COUNTER_BITS'(sample) - COUNTER_BITS'(first_reg);
    assign period_ext  = EXT_W'(period_full);

    // one restoring step: shift in the next dividend bit, subtract when it fits
    assign shifted = {rem_reg, quo_reg[FREQ_W-1]};
    assign diff    = shifted - {1'b0, divisor_reg};
    assign fits    = !diff[COUNTER_BITS];

    assign status.zero_period = (period_full == '0);
    assign status.out_free    = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= '0;
        end else if (cmd.load_first) begin
            first_reg <= sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            divisor_reg <= period_full;
            rem_reg     <= '0;
            quo_reg     <= clock_hz;
            zero_reg    <= (period_full == '0);
            period_reg  <= period_ext[PERIOD_W-1:0];
        end else if (cmd.step) begin
            rem_reg <= fits ? diff[COUNTER_BITS-1:0] : shifted[COUNTER_BITS-1:0];
            quo_reg <= {quo_reg[FREQ_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {(zero_reg ? {FREQ_W{1'b0}} : quo_reg), period_reg};
            out_zero_reg <= zero_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_zero_reg;

endmodule

[sv/capture_frequency_meter_unit.sv]
// Channel   Direction  Payload
// s_axis    in         tdata[15:0] captured_count
// m_axis    out        tdata[15:0] period_ticks, tdata[47:16] frequency_hz,
//                      tuser[0] zero_period
// apb       in/out     register 0 at byte 0: clock_hz (32 bits)
//
// A first capture of a pair gives no result.
// A second capture reaches the output register in three steps: the period is latched,
// the restoring divider runs (one quotient bit a cycle), and the result is loaded once the output register is free.
// Equal captures bypass the divider and go straight to the load step.
// Reset is synchronous on aresetn low; clock_hz returns to 168000000.
// A stalled result holds in the output register; further captures are taken
// while it waits, until the next finished result needs that register.
module capture_frequency_meter_unit #(
    parameter int COUNTER_BITS = cfm_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // captured stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [cfm_pkg::S_DATA_W-1:0]    s_axis_tdata,   // [15:0] captured_count
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cfm_pkg::M_DATA_W-1:0]    m_axis_tdata,   // [15:0] period_ticks,
                                                            // [47:16] frequency_hz
    output logic                            m_axis_tuser,   // [0] zero_period
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cfm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [cfm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [cfm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import cfm_pkg::*;

    logic [CFG_DATA_W-1:0] clock_hz_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic                  cfg_write;
    cfm_cmd_t              cmd;
    cfm_status_t           status;

    // Registers sit on 32-bit word boundaries; decode the word index only
    assign reg_idx   = paddr[CFG_ADDR_W-1:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Drop writes to unmapped words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLOCK_HZ_RESET;
        end else if (cfg_write && (reg_idx == REG_IDX_CLOCK_HZ)) begin
            clock_hz_reg <= pwdata;
        end
    end

    assign prdata = (reg_idx == REG_IDX_CLOCK_HZ) ? clock_hz_reg : '0;

    // Sequencing: capture pairing, divider iteration count, output hand-off
    cfm_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // Period subtractor, single divider and output register
    cfm_datapath #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .clock_hz      (clock_hz_reg),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // A result may only be loaded into a free or draining output register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a waiting transaction");

    // No capture is taken while the divider iterates
    a_no_accept_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> !s_axis_tready)
        else $error("capture accepted during division");

    // A zero period reports zero frequency
    a_zero_freq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[M_DATA_W-1:PERIOD_W] == '0))
        else $error("zero period with non-zero frequency");

    // A load follows a division or a zero-period start, never an idle cycle
    a_load_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !s_axis_tready)
        else $error("result loaded while idle");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

// Checks the capture frequency meter: a directed table of capture pairs and
// register writes, then random phases at several clock_hz settings. Every
// accepted capture goes through a local predictor. Each result transaction is
// checked against the oldest queued measurement.
module testbench;
    import cfm_pkg::*;

    // Spare register index: writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE = CFG_IDX_W'(1);

    // Cycles to let the block settle: divider length plus margin
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 160;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [FREQ_W-1:0]   freq;
        logic                zero;
    } measurement_t;

    typedef enum logic {
        ROW_CAPTURE,
        ROW_WRITE
    } row_kind_t;

    // One line of the directed plan. For a capture, value[15:0] is the count;
    // typed marks rows whose result is given literally in want.
    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          value;
        logic                 typed;
        measurement_t         want;
    } plan_row_t;

    localparam measurement_t NO_WANT = '0;
    localparam int PLAN_ROWS = 28;

    // Directed plan: extremes, counter wrap, equal captures, clock extremes,
    // zero clock and a write to the spare index.
    plan_row_t directed_plan [PLAN_ROWS] = '{
        '{ROW_CAPTURE, '0, 32'h0000, 1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'h0001, 1'b1, '{16'd1, 32'd168000000, 1'b0}},
        '{ROW_CAPTURE, '0, 32'd100,  1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'd100,  1'b1, '{16'd0, 32'd0, 1'b1}},
        '{ROW_CAPTURE, '0, 32'hFFFF, 1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'h0000, 1'b1, '{16'd1, 32'd168000000, 1'b0}},
        '{ROW_CAPTURE, '0, 32'h0000, 1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'hFFFF, 1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'hFFFF, 1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'hFFFF, 1'b1, '{16'd0, 32'd0, 1'b1}},
        '{ROW_CAPTURE, '0, 32'h5555, 1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'hAAAA, 1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'd1234, 1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'd1334, 1'b1, '{16'd100, 32'd1680000, 1'b0}},
        '{ROW_WRITE, REG_IDX_CLOCK_HZ, 32'hFFFF_FFFF, 1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'd7,    1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'd8,    1'b1, '{16'd1, 32'hFFFF_FFFF, 1'b0}},
        '{ROW_WRITE, REG_IDX_CLOCK_HZ, 32'd0, 1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'd10,   1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'd20,   1'b1, '{16'd10, 32'd0, 1'b0}},
        '{ROW_WRITE, REG_IDX_SPARE, 32'd12345, 1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'd3,    1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'd4,    1'b1, '{16'd1, 32'd0, 1'b0}},
        '{ROW_WRITE, REG_IDX_CLOCK_HZ, 32'd1, 1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'hAAAA, 1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'h5555, 1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'd2,    1'b0, NO_WANT},
        '{ROW_CAPTURE, '0, 32'd3,    1'b1, '{16'd1, 32'd1, 1'b0}}
    };

    // Every input driven to a known value from time zero
    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;   // [15:0] captured_count
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;         // [15:0] period_ticks, [47:16] frequency_hz
    logic                  m_axis_tuser;         // [0] zero_period
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state: its own copy of the register and of the pair tracking
    logic [CFG_DATA_W-1:0] clock_hz_copy   = CLOCK_HZ_RESET;
    logic                  awaiting_second = 1'b0;
    logic [CAPTURE_W-1:0]  held_first      = '0;

    measurement_t pending_measurements [$];
    int  failures  = 0;
    int  hold_left = 0;
    bit  calm      = 1'b0;   // no idling on either side once set

    capture_frequency_meter_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // Advance the pair tracking by one capture; return 1 when a measurement
    // falls out. The period wraps naturally in 16 bits; equal captures skip
    // the division and flag a zero period.
    function automatic bit measure_capture(input logic [CAPTURE_W-1:0] count,
                                           output measurement_t m);
        logic [PERIOD_W-1:0] span;
        m = '0;
        if (!awaiting_second) begin
            held_first      = count;
            awaiting_second = 1'b1;
            return 1'b0;
        end
        span            = count - held_first;
        awaiting_second = 1'b0;
        m.period = span;
        m.zero   = (span == '0);
        m.freq   = (span == '0) ? '0 : clock_hz_copy / {16'd0, span};
        return 1'b1;
    endfunction

    // Offer one capture after an optional gap and hold it until accepted.
    // Entered and left just after a rising edge.
    task automatic send_capture(input logic [CAPTURE_W-1:0] count, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= count;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Random sender gap: now and then a burst of idle cycles of random length
    function automatic int sender_gap();
        if (calm || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 16);
    endfunction

    // Two-phase bus transaction; idling after it keeps drives apart
    task automatic bus_transfer(input logic write, input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] wdata,
                                output logic [CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Drain the block, write a register, then read clock_hz back
    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] readback;
        s_axis_tvalid <= 1'b0;
        while (pending_measurements.size() != 0) @(posedge aclk);
        // A dangling first capture gives no result; let the block go quiet
        repeat (SETTLE_CYCLES) @(posedge aclk);
        bus_transfer(1'b1, idx, value, readback);
        if (idx == REG_IDX_CLOCK_HZ)
            clock_hz_copy = value;
        bus_transfer(1'b0, REG_IDX_CLOCK_HZ, '0, readback);
        if (readback !== clock_hz_copy) begin
            $display("%0t: clock_hz readback expected %0d actual %0d",
                     $time, clock_hz_copy, readback);
            failures++;
        end
    endtask

    // Result side stall: bursts of random length with tready low
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold_left     <= $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest queued measurement
    always @(posedge aclk) begin
        measurement_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_measurements.size() == 0) begin
                $display("%0t: unexpected result, period %0d freq %0d zero %0b",
                         $time, m_axis_tdata[15:0], m_axis_tdata[47:16], m_axis_tuser);
                failures++;
            end else begin
                want = pending_measurements.pop_front();
                if (m_axis_tdata[15:0] !== want.period) begin
                    $display("%0t: period_ticks expected %0d actual %0d",
                             $time, want.period, m_axis_tdata[15:0]);
                    failures++;
                end
                if (m_axis_tdata[47:16] !== want.freq) begin
                    $display("%0t: frequency_hz expected %0d actual %0d",
                             $time, want.freq, m_axis_tdata[47:16]);
                    failures++;
                end
                if (m_axis_tuser !== want.zero) begin
                    $display("%0t: zero_period expected %0b actual %0b",
                             $time, want.zero, m_axis_tuser);
                    failures++;
                end
            end
        end
    end

    initial begin
        measurement_t          m;
        logic [CAPTURE_W-1:0]  count;
        logic [CFG_DATA_W-1:0] readback;
        logic [CFG_DATA_W-1:0] rate;
        plan_row_t             row;

        // Hold reset, then release it for good
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The register must come out of reset at its default
        bus_transfer(1'b0, REG_IDX_CLOCK_HZ, '0, readback);
        if (readback !== CLOCK_HZ_RESET) begin
            $display("%0t: clock_hz after reset expected %0d actual %0d",
                     $time, CLOCK_HZ_RESET, readback);
            failures++;
        end

        // Walk the directed plan; typed rows queue their literal result
        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.kind == ROW_WRITE) begin
                program_register(row.idx, row.value);
            end else begin
                send_capture(row.value[CAPTURE_W-1:0], sender_gap());
                if (measure_capture(row.value[CAPTURE_W-1:0], m))
                    pending_measurements.push_back(row.typed ? row.want : m);
            end
        end

        // Random phases, each at its own clock_hz; the last one runs flat out
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       rate = CLOCK_HZ_RESET;
                1:       rate = 32'hFFFF_FFFF;
                2:       rate = '0;
                3:       rate = $urandom_range(1, 1000);
                default: rate = $urandom();
            endcase
            if (p % 2 == 1)
                program_register(REG_IDX_SPARE, $urandom());
            program_register(REG_IDX_CLOCK_HZ, rate);
            calm = (p == RANDOM_PHASES - 1);

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Second captures lean towards equal, near and just-wrapped counts
                if (!awaiting_second) begin
                    count = CAPTURE_W'($urandom());
                end else begin
                    case ($urandom_range(0, 9))
                        0:       count = held_first;
                        1, 2:    count = held_first + CAPTURE_W'($urandom_range(1, 16));
                        3:       count = held_first - CAPTURE_W'($urandom_range(1, 16));
                        default: count = CAPTURE_W'($urandom());
                    endcase
                end
                send_capture(count, sender_gap());
                if (measure_capture(count, m))
                    pending_measurements.push_back(m);
            end
        end

        // Let every outstanding result arrive, then allow for the latency
        s_axis_tvalid <= 1'b0;
        while (pending_measurements.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
